// ----- rtl/scan_disk_request_order_core_assert.svh -----
// Assertion macros used by the core RTL file.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message.
`ifndef SCAN_DISK_REQUEST_ORDER_CORE_ASSERT_SVH
`define SCAN_DISK_REQUEST_ORDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SCDRO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SCDRO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCDRO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SCDRO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/scdro_pkg.sv -----
package scdro_pkg;

  // Sizes
  localparam int unsigned MAX_REQUESTS = 16;
  localparam int unsigned TRACK_W      = 12;
  localparam int unsigned SEEK_W       = 13;
  localparam int unsigned IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CNT_W        = $clog2(MAX_REQUESTS + 1);

  typedef logic [TRACK_W-1:0] track_t;
  typedef logic [SEEK_W-1:0]  seek_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;

  localparam seek_t SEEK_MAX = {SEEK_W{1'b1}};
  localparam cnt_t  CNT_FULL = CNT_W'(MAX_REQUESTS);

  // Control from the sequencer to the request store
  typedef struct packed {
    logic   wr;
    track_t wr_data;
    logic   clr_cnt;
    logic   clr_used;
    logic   mark;
    idx_t   mark_idx;
    idx_t   rd_idx;
  } store_ctl_t;

endpackage

// ----- rtl/scdro_if.sv -----
// Request channel
interface scdro_req_if;
  import scdro_pkg::*;
  logic   valid;
  logic   ready;
  track_t request_track;
  logic   last_request;
  modport source (output valid, output request_track, output last_request, input ready);
  modport sink (input valid, input request_track, input last_request, output ready);
endinterface

// Result channel
interface scdro_res_if;
  import scdro_pkg::*;
  logic   valid;
  logic   ready;
  track_t served_track;
  seek_t  seek_total;
  logic   last_result;
  modport source (output valid, output served_track, output seek_total, output last_result,
                  input ready);
  modport sink (input valid, input served_track, input seek_total, input last_result,
                output ready);
endinterface

// Head position write channel
interface scdro_cfg_if;
  import scdro_pkg::*;
  logic   valid;
  logic   ready;
  track_t head_position;
  modport source (output valid, output head_position, input ready);
  modport sink (input valid, input head_position, output ready);
endinterface

// ----- rtl/scdro_store.sv -----
module scdro_store
  import scdro_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  store_ctl_t              ctl_i,
  output track_t                  rd_data_o,
  output cnt_t                    count_o,
  output logic [MAX_REQUESTS-1:0] used_o
);

  track_t                  mem_q [MAX_REQUESTS];
  cnt_t                    count_q;
  logic [MAX_REQUESTS-1:0] used_q;

  // Request storage, appended in arrival order
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[count_q[IDX_W-1:0]] <= ctl_i.wr_data;
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.clr_cnt) begin
      count_q <= '0;
    end else if (ctl_i.wr) begin
      count_q <= count_q + cnt_t'(1);
    end
  end

  // Entries already served in this batch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ctl_i.clr_used) begin
      used_q <= '0;
    end else if (ctl_i.mark) begin
      used_q[ctl_i.mark_idx] <= 1'b1;
    end
  end

  assign rd_data_o = mem_q[ctl_i.rd_idx];
  assign count_o   = count_q;
  assign used_o    = used_q;

endmodule

// ----- rtl/scdro_eval.sv -----
// Shared candidate compare and distance unit
module scdro_eval
  import scdro_pkg::*;
(
  input  track_t cand_i,
  input  logic   cand_used_i,
  input  track_t head_i,
  input  track_t best_i,
  input  logic   found_i,
  input  logic   phase_dn_i,
  input  track_t pos_i,
  output logic   take_o,
  output track_t travel_o
);

  logic above, below, beats_up, beats_dn;

  always_comb begin
    above    = cand_i > head_i;
    below    = cand_i < head_i;
    // strict compare keeps the earliest copy of a duplicate first
    beats_up = !found_i || (cand_i < best_i);
    beats_dn = !found_i || (cand_i > best_i);
    if (phase_dn_i) begin
      take_o = !cand_used_i && below && beats_dn;
    end else begin
      take_o = !cand_used_i && above && beats_up;
    end
  end

  // Head travel from the current position to the chosen track
  assign travel_o = (best_i >= pos_i) ? (best_i - pos_i) : (pos_i - best_i);

endmodule

// ----- rtl/scan_disk_request_order_core.sv -----
// A non-final request beat is stored unless it matches the head position or the store
// is full, and yields no result. After the final beat, each result follows one scan of
// the stored requests by the shared compare unit, and the turn takes one more scan.
// Throughput: 1 request beat per cycle while loading; the input is not ready
// while the ordering runs. Reset clears the fill count, served flags, state and head
// (0); request storage is not cleared.
`include "scan_disk_request_order_core_assert.svh"

module scan_disk_request_order_core
  import scdro_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  scdro_req_if.sink   req_i,
  scdro_res_if.source res_o,
  scdro_cfg_if.sink   cfg_i
);

  localparam logic S_LOAD = 1'b0;
  localparam logic S_SCAN = 1'b1;
  localparam logic PH_UP  = 1'b0;
  localparam logic PH_DN  = 1'b1;

  logic   state_q, phase_q, found_q;
  cnt_t   idx_q;
  idx_t   best_idx_q;
  track_t best_q, pend_track_q, head_q;
  seek_t  pend_seek_q;

  logic   res_valid_q, res_last_q;
  track_t res_track_q;
  seek_t  res_seek_q;

  store_ctl_t              ctl;
  track_t                  rd_data, travel;
  cnt_t                    count;
  logic [MAX_REQUESTS-1:0] used;
  logic                    take, req_acc, scan_more, out_free, push_mid, push_last;
  logic [SEEK_W:0]         seek_sum;
  seek_t                   seek_next;

  // Head position register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (cfg_i.valid) begin
      head_q <= cfg_i.head_position;
    end
  end

  // Handshake and scan control
  assign req_i.ready = (state_q == S_LOAD);
  assign req_acc     = req_i.valid && req_i.ready;
  assign scan_more   = (state_q == S_SCAN) && (idx_q < count);
  assign out_free    = !res_valid_q || res_o.ready;
  assign push_mid    = (state_q == S_SCAN) && !scan_more && found_q && out_free;
  assign push_last   = (state_q == S_SCAN) && !scan_more && !found_q && (phase_q == PH_DN)
                       && out_free;

  always_comb begin
    ctl.wr       = req_acc && (req_i.request_track != head_q) && (count < CNT_FULL);
    ctl.wr_data  = req_i.request_track;
    ctl.clr_cnt  = push_last;
    ctl.clr_used = req_acc && req_i.last_request;
    ctl.mark     = push_mid;
    ctl.mark_idx = best_idx_q;
    ctl.rd_idx   = idx_q[IDX_W-1:0];
  end

  scdro_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .rd_data_o(rd_data),
    .count_o  (count),
    .used_o   (used)
  );

  scdro_eval u_eval (
    .cand_i     (rd_data),
    .cand_used_i(used[idx_q[IDX_W-1:0]]),
    .head_i     (head_q),
    .best_i     (best_q),
    .found_i    (found_q),
    .phase_dn_i (phase_q == PH_DN),
    .pos_i      (pend_track_q),
    .take_o     (take),
    .travel_o   (travel)
  );

  // Running seek total, saturating
  assign seek_sum  = {1'b0, pend_seek_q} + (SEEK_W + 1)'(travel);
  assign seek_next = seek_sum[SEEK_W] ? SEEK_MAX : seek_sum[SEEK_W-1:0];

  // Sequencer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      phase_q <= PH_UP;
      found_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (req_acc && req_i.last_request) begin
            state_q <= S_SCAN;
            phase_q <= PH_UP;
            found_q <= 1'b0;
            idx_q   <= '0;
          end
        end
        S_SCAN: begin
          if (scan_more) begin
            if (take) begin
              found_q <= 1'b1;
            end
            idx_q <= idx_q + cnt_t'(1);
          end else if (found_q) begin
            if (out_free) begin
              found_q <= 1'b0;
              idx_q   <= '0;
            end
          end else if (phase_q == PH_UP) begin
            phase_q <= PH_DN;
            idx_q   <= '0;
          end else if (out_free) begin
            state_q <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  // Sequencer payload: best candidate and the pending result
  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.last_request) begin
      pend_track_q <= head_q;
      pend_seek_q  <= '0;
    end else if (push_mid) begin
      pend_track_q <= best_q;
      pend_seek_q  <= seek_next;
    end
    if (scan_more && take) begin
      best_q     <= rd_data;
      best_idx_q <= idx_q[IDX_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (push_mid || push_last) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_mid || push_last) begin
      res_track_q <= pend_track_q;
      res_seek_q  <= pend_seek_q;
      res_last_q  <= push_last;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.served_track = res_track_q;
  assign res_o.seek_total   = res_seek_q;
  assign res_o.last_result  = res_last_q;

  // Checks
  `SCDRO_ASSERT_IMP(a_idx_bound, clk_i, rst_ni, state_q == S_SCAN, idx_q <= count, "scan index past fill count")
  `SCDRO_ASSERT_NXT(a_last_clears, clk_i, rst_ni, push_last, (count == '0) && (state_q == S_LOAD), "batch not cleared after final beat")
  `SCDRO_ASSERT_IMP(a_mark_fresh, clk_i, rst_ni, push_mid, !used[best_idx_q], "entry served twice")

endmodule
